// ===== rtl/stpm_pkg.sv =====
// shared types and constants of the stereo timestamp pair matcher
package stpm_pkg;

  localparam int unsigned TIME_BITS   = 64;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned WINDOW_BITS = 32;

  localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 32'd70_000_000;

  // one input transfer
  typedef struct packed {
    logic                 left_present;
    logic [TIME_BITS-1:0] left_time;
    logic [TAG_BITS-1:0]  left_tag;
    logic                 right_present;
    logic [TIME_BITS-1:0] right_time;
    logic [TAG_BITS-1:0]  right_tag;
  } stpm_in_t;

  // one matched pair
  typedef struct packed {
    logic [TAG_BITS-1:0]  pair_left_tag;
    logic [TIME_BITS-1:0] pair_left_time;
    logic [TAG_BITS-1:0]  pair_right_tag;
    logic [TIME_BITS-1:0] pair_right_time;
  } stpm_pair_t;

  // one queued frame
  typedef struct packed {
    logic [TIME_BITS-1:0] ts;
    logic [TAG_BITS-1:0]  tag;
  } stpm_frame_t;

  // queue control from the sequencer
  typedef struct packed {
    logic load;     // new input transfer: drop oldest if full, then maybe push
    logic present;  // frame carried with the load
    logic pop;      // pop the head
  } stpm_qctl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_NEG,
    ST_CHECK
  } stpm_state_e;

endpackage

// ===== rtl/stpm_queue.sv =====
// shift-register frame queue with drop-oldest on overflow
module stpm_queue #(
  parameter int unsigned DEPTH = 3,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stpm_pkg::stpm_qctl_t ctl_i,
  input  stpm_pkg::stpm_frame_t frame_i,
  output stpm_pkg::stpm_frame_t head_o,
  output logic                nonempty_o
);

  stpm_pkg::stpm_frame_t entry_q [DEPTH];
  stpm_pkg::stpm_frame_t entry_d [DEPTH];
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  full;
  logic                  shift;
  logic                  write;
  logic [CNT_W-1:0]      wpos;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign shift = (ctl_i.load & full) | (ctl_i.pop & (count_q != '0));
  assign write = ctl_i.load & ctl_i.present;
  assign wpos  = count_q - CNT_W'(shift);

  // next entries: shift toward the head, then write at the tail
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_d[i] = entry_q[i];
      if (write && (wpos == CNT_W'(i))) begin
        entry_d[i] = frame_i;
      end else if (shift && (i < DEPTH - 1)) begin
        entry_d[i] = entry_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
    count_d = wpos + CNT_W'(write);
  end

  // entries hold no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o     = entry_q[0];
  assign nonempty_o = (count_q != '0);

endmodule

// ===== rtl/stereo_timestamp_pair_matcher.sv =====
// top level: pairs left and right camera frames by timestamp
//
//   channel  | signals                      | moves
//   ---------+------------------------------+------------------------------
//   in       | in_valid_i/in_ready_o        | stpm_in_t, one step of frames
//   out      | out_valid_o/out_ready_i      | stpm_pair_t, one matched pair
//   cfg      | cfg_we_i/cfg_wdata_i         | sync window in ns, no wait
//
// an input transfer drops/pushes in idle, then each head compare passes diff,
// neg (only when left is older) and check (one shared 64-bit subtractor, used
// twice when left is older). a step ends in idle after a pair or when a queue
// is empty, and no new transfer is taken until then.
// reset empties both queues and loads the 70 ms window; no clearing pass.
// a pair waiting on a full output register stalls the sequencer in check.
module stereo_timestamp_pair_matcher #(
  parameter int unsigned QUEUE_DEPTH = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  stpm_pkg::stpm_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output stpm_pkg::stpm_pair_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [stpm_pkg::WINDOW_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned TW = stpm_pkg::TIME_BITS;
  localparam int unsigned WW = stpm_pkg::WINDOW_BITS;

  stpm_pkg::stpm_state_e state_q, state_d;
  stpm_pkg::stpm_qctl_t  lctl, rctl;
  stpm_pkg::stpm_frame_t lframe, rframe, lhead, rhead;
  stpm_pkg::stpm_pair_t  out_data_q;
  logic                  lnonempty, rnonempty;
  logic [WW-1:0]         window_q;
  logic [TW-1:0]         diff_q, diff_d;
  logic                  lt_less_q, lt_less_d;
  logic [TW-1:0]         sub_a, sub_b;
  logic [TW:0]           sub_res;
  logic                  swap_sel;
  logic                  in_window;
  logic                  out_free;
  logic                  out_load;
  logic                  out_valid_q;
  logic                  accept;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // incoming frames
  assign lframe = '{ts: in_data_i.left_time, tag: in_data_i.left_tag};
  assign rframe = '{ts: in_data_i.right_time, tag: in_data_i.right_tag};

  stpm_queue #(.DEPTH(QUEUE_DEPTH)) u_left_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (lctl),
    .frame_i    (lframe),
    .head_o     (lhead),
    .nonempty_o (lnonempty)
  );

  stpm_queue #(.DEPTH(QUEUE_DEPTH)) u_right_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (rctl),
    .frame_i    (rframe),
    .head_o     (rhead),
    .nonempty_o (rnonempty)
  );

  // shared subtractor, operands swapped for the second pass
  assign sub_a   = swap_sel ? rhead.ts : lhead.ts;
  assign sub_b   = swap_sel ? lhead.ts : rhead.ts;
  assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

  // absolute difference below the window
  assign in_window = (diff_q[TW-1:WW] == '0) && (diff_q[WW-1:0] < window_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stpm_pkg::ST_IDLE: begin
        if (accept) state_d = stpm_pkg::ST_DIFF;
      end
      stpm_pkg::ST_DIFF: begin
        if (!(lnonempty && rnonempty)) state_d = stpm_pkg::ST_IDLE;
        else if (sub_res[TW])          state_d = stpm_pkg::ST_NEG;
        else                           state_d = stpm_pkg::ST_CHECK;
      end
      stpm_pkg::ST_NEG: begin
        state_d = stpm_pkg::ST_CHECK;
      end
      stpm_pkg::ST_CHECK: begin
        if (!in_window)    state_d = stpm_pkg::ST_DIFF;
        else if (out_free) state_d = stpm_pkg::ST_IDLE;
      end
      default: state_d = stpm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    swap_sel   = 1'b0;
    out_load   = 1'b0;
    diff_d     = diff_q;
    lt_less_d  = lt_less_q;
    lctl       = '{load: 1'b0, present: 1'b0, pop: 1'b0};
    rctl       = '{load: 1'b0, present: 1'b0, pop: 1'b0};
    case (state_q)
      stpm_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        lctl.load    = accept;
        lctl.present = in_data_i.left_present;
        rctl.load    = accept;
        rctl.present = in_data_i.right_present;
      end
      stpm_pkg::ST_DIFF: begin
        diff_d    = sub_res[TW-1:0];
        lt_less_d = sub_res[TW];
      end
      stpm_pkg::ST_NEG: begin
        swap_sel = 1'b1;
        diff_d   = sub_res[TW-1:0];
      end
      stpm_pkg::ST_CHECK: begin
        if (in_window) begin
          out_load = out_free;
          lctl.pop = out_free;
          rctl.pop = out_free;
        end else begin
          lctl.pop = lt_less_q;
          rctl.pop = ~lt_less_q;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stpm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      window_q    <= stpm_pkg::WINDOW_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~out_ready_i);
      if (cfg_we_i) window_q <= cfg_wdata_i;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    lt_less_q <= lt_less_d;
    if (out_load) begin
      out_data_q <= '{pair_left_tag:   lhead.tag,
                      pair_left_time:  lhead.ts,
                      pair_right_tag:  rhead.tag,
                      pair_right_time: rhead.ts};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/stpm_checker.sv =====
// port-level checker for the pair matcher, bound to the top level
module stpm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input stpm_pkg::stpm_pair_t out_data_o
);

  // a stalled pair holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("pair changed or dropped while stalled");

  // the block is busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again without processing");

  // a new pair appears only out of processing
  a_pair_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("pair appeared while idle");

  // a new pair never appears while the block is idle and ready
  a_pair_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_ready_o |=> !out_valid_o)
    else $error("pair appeared without an input transfer");

endmodule

bind stereo_timestamp_pair_matcher stpm_checker u_stpm_checker (.*);
